>>> hdl/mbss_pkg.sv
// Package for the masked byte signature scanner.
// Holds register indexes, field widths and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package mbss_pkg;

  // Default depth of the byte window (pattern positions).
  localparam int PATTERN_MAX_DEFAULT = 32;

  // The pattern registers always hold 32 bytes; positions beyond them are wildcards.
  localparam int PATTERN_BYTES = 32;
  localparam int PIDX_W        = 5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ADDR_W      = 64;
  localparam int HIT_W       = 16;
  localparam int PLEN_W      = 6;
  // Effective length, clamped to 1..PATTERN_MAX, is held one bit wider than the register.
  localparam int LEN_W       = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HITS  = 3'd6;

  typedef struct packed {
    logic [PATTERN_BYTES-1:0][7:0] pattern;
    logic [PATTERN_BYTES-1:0]      care_mask;
    logic [PLEN_W-1:0]             pattern_length;
    logic [HIT_W-1:0]              max_hits;
  } cfg_t;

  // Control of the word held in the window stage.
  typedef struct packed {
    logic valid;
    logic search;
  } stage_ctrl_t;

  // Outcome of the window compare.
  typedef struct packed {
    logic              hit;
    logic [PLEN_W-1:0] len_minus1;
  } match_t;

endpackage

>>> hdl/mbss_in_if.sv
// Input channel of the scanner: one scanned byte with its address and flags.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

interface mbss_in_if import mbss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic [ADDR_W-1:0] byte_address;
  logic              region_start;
  logic              search_start;

  modport source (output valid, data_byte, byte_address, region_start, search_start,
                  input ready);
  modport sink   (input valid, data_byte, byte_address, region_start, search_start,
                  output ready);
endinterface

>>> hdl/mbss_out_if.sv
// Result channel of the scanner: one match report.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

interface mbss_out_if import mbss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] match_address;
  logic [HIT_W-1:0]  match_number;
  logic              last_hit;

  modport source (output valid, match_address, match_number, last_hit, input ready);
  modport sink   (input valid, match_address, match_number, last_hit, output ready);
endinterface

>>> hdl/mbss_cfg_if.sv
// Configuration write channel of the scanner: register index and write data.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

interface mbss_cfg_if import mbss_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/mbss_cfg_regs.sv
// Configuration register file of the scanner.
// Depends on mbss_pkg and mbss_cfg_if.
`timescale 1ns / 1ps

module mbss_cfg_regs import mbss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mbss_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern        <= '0;
      regs.care_mask      <= '0;
      regs.pattern_length <= PLEN_W'(1);
      regs.max_hits       <= HIT_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_A: regs.pattern[7:0]   <= cfg.data;
        REG_PATTERN_B: regs.pattern[15:8]  <= cfg.data;
        REG_PATTERN_C: regs.pattern[23:16] <= cfg.data;
        REG_PATTERN_D: regs.pattern[31:24] <= cfg.data;
        REG_CARE_MASK: regs.care_mask      <= cfg.data[PATTERN_BYTES-1:0];
        REG_PAT_LEN:   regs.pattern_length <= cfg.data[PLEN_W-1:0];
        REG_MAX_HITS:  regs.max_hits       <= cfg.data[HIT_W-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

>>> hdl/mbss_window.sv
// Input stage of the scanner: byte window shift register, fill count and the
// registered address and search flag of the word in flight. Depends on mbss_pkg.
`timescale 1ns / 1ps

module mbss_window import mbss_pkg::*; #(
  parameter  int PATTERN_MAX = PATTERN_MAX_DEFAULT,
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic                         drain,
  input  logic [7:0]                   data_byte,
  input  logic [ADDR_W-1:0]            byte_address,
  input  logic                         region_start,
  input  logic                         search_start,
  output logic [PATTERN_MAX-1:0][7:0]  window,
  output logic [FILL_W-1:0]            fill,
  output logic [ADDR_W-1:0]            addr,
  output stage_ctrl_t                  ctrl
);

  logic [PATTERN_MAX-1:0][7:0] window_next;
  logic [FILL_W-1:0]           fill_base;
  logic [FILL_W-1:0]           fill_next;

  // Entry 0 is the newest byte.
  always_comb begin
    window_next[0] = data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
  end

  always_comb begin
    fill_base = (region_start || search_start) ? '0 : fill;
    fill_next = (fill_base == FILL_W'(PATTERN_MAX)) ? fill_base : fill_base + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      ctrl.valid  <= 1'b0;
      ctrl.search <= 1'b0;
    end else if (take) begin
      fill        <= fill_next;
      ctrl.valid  <= 1'b1;
      ctrl.search <= search_start;
    end else if (drain) begin
      ctrl.valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      window <= window_next;
      addr   <= byte_address;
    end
  end

endmodule

>>> hdl/mbss_match.sv
// Window compare of the scanner: aligns the pattern to the window for the
// configured length and checks every cared-for position. Depends on mbss_pkg.
`timescale 1ns / 1ps

module mbss_match import mbss_pkg::*; #(
  parameter  int PATTERN_MAX = PATTERN_MAX_DEFAULT,
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1)
) (
  input  cfg_t                        regs,
  input  logic [PATTERN_MAX-1:0][7:0] window,
  input  logic [FILL_W-1:0]           fill,
  output match_t                      result
);

  logic [LEN_W-1:0]            len_eff;
  logic [PATTERN_MAX-1:0][7:0] pat_al;
  logic [PATTERN_MAX-1:0]      care_al;
  logic [PATTERN_MAX-1:0]      pos_ok;

  always_comb begin
    len_eff = LEN_W'(regs.pattern_length);
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_eff > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end
  end

  // Window entry j holds the byte for pattern position len - 1 - j. The
  // alignment only moves when the length register is rewritten.
  always_comb begin
    int p;
    logic [PIDX_W-1:0] pidx;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      p    = int'(len_eff) - 1 - j;
      pidx = p[PIDX_W-1:0];
      if (p >= 0 && p < PATTERN_BYTES) begin
        pat_al[j]  = regs.pattern[pidx];
        care_al[j] = regs.care_mask[pidx];
      end else begin
        pat_al[j]  = 8'h00;
        care_al[j] = 1'b0;
      end
      pos_ok[j] = !care_al[j] || (window[j] == pat_al[j]);
    end
  end

  assign result.hit        = (LEN_W'(fill) >= len_eff) && (&pos_ok);
  assign result.len_minus1 = PLEN_W'(len_eff - LEN_W'(1));

endmodule

>>> hdl/masked_byte_signature_scan.sv
// Masked byte signature scanner, top level. Takes one scanned byte word per
// cycle while the window stage is not held, and reports the start address of
// every window that matches the masked pattern, up to the configured hit limit
// per search. The edge that accepts a byte shifts it into the byte window; the
// window is compared at all positions in parallel, and the edge at which the
// window stage drains updates the hit count and loads the result register.
// While a finished report waits on the result channel, the window stage keeps
// accepting as long as its words give no hit; a word that hits holds the window
// stage, and with it the input, until the result register is free. Depends on
// mbss_pkg, the three channel interfaces, mbss_cfg_regs, mbss_window and
// mbss_match.
`timescale 1ns / 1ps

module masked_byte_signature_scan import mbss_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  mbss_in_if.sink     scan_in,
  mbss_out_if.source  hit_out,
  mbss_cfg_if.sink    cfg
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  cfg_t                        regs;
  logic [PATTERN_MAX-1:0][7:0] window;
  logic [FILL_W-1:0]           fill;
  logic [ADDR_W-1:0]           stage_addr;
  stage_ctrl_t                 stage;
  match_t                      cmp;

  logic                        take;
  logic                        drain;
  logic                        res_free;
  logic                        hit_now;
  logic [HIT_W-1:0]            hit_base;
  logic [HIT_W-1:0]            hit_inc;

  // Hit counter and result register.
  logic [HIT_W-1:0]            hit_count;
  logic                        res_valid;
  logic [ADDR_W-1:0]           res_address;
  logic [HIT_W-1:0]            res_number;
  logic                        res_last;

  mbss_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mbss_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .drain        (drain),
    .data_byte    (scan_in.data_byte),
    .byte_address (scan_in.byte_address),
    .region_start (scan_in.region_start),
    .search_start (scan_in.search_start),
    .window       (window),
    .fill         (fill),
    .addr         (stage_addr),
    .ctrl         (stage)
  );

  mbss_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .regs   (regs),
    .window (window),
    .fill   (fill),
    .result (cmp)
  );

  // A new search clears the count for the word that starts it. A hit counts
  // only while the count is still below the limit, so a zero limit never hits.
  always_comb begin
    hit_base = stage.search ? '0 : hit_count;
    hit_now  = cmp.hit && (hit_base < regs.max_hits);
    hit_inc  = hit_base + 1'b1;
  end

  // The result register is free when empty or being taken this cycle. The
  // window stage drains when its word either lands there or gives no report.
  assign res_free      = !res_valid || hit_out.ready;
  assign drain         = stage.valid && (res_free || !hit_now);
  assign scan_in.ready = !stage.valid || drain;
  assign take          = scan_in.valid && scan_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (drain) begin
        hit_count <= hit_now ? hit_inc : hit_base;
      end
      if (drain && hit_now) begin
        res_valid <= 1'b1;
      end else if (hit_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The match start address wraps modulo two to the 64th.
  always_ff @(posedge clk) begin
    if (drain && hit_now) begin
      res_address <= stage_addr - ADDR_W'(cmp.len_minus1);
      res_number  <= hit_inc;
      res_last    <= (hit_inc >= regs.max_hits);
    end
  end

  assign hit_out.valid         = res_valid;
  assign hit_out.match_address = res_address;
  assign hit_out.match_number  = res_number;
  assign hit_out.last_hit      = res_last;

endmodule

>>> dv/masked_byte_signature_scan_tb.sv
// Self-checking testbench for the masked byte signature scanner.
// Drives byte words and register writes, predicts match reports and checks them in order.
// Depends on mbss_pkg, the three channel interfaces and masked_byte_signature_scan.
`timescale 1ns / 1ps

module masked_byte_signature_scan_tb;
  import mbss_pkg::*;

  localparam int SCAN_DEPTH       = PATTERN_MAX_DEFAULT;
  localparam int ITEM_TARGET      = 1150;
  localparam int PHASE_ITEMS      = 110;
  localparam int CALM_ITEMS       = 160;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 8;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT   = 2000;

  // Index 7 is outside the register list; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // One scanned byte word as the input channel carries it.
  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              region;
    logic              search;
  } scan_word_t;

  // One match report as the result channel carries it.
  typedef struct packed {
    logic [ADDR_W-1:0] match_address;
    logic [HIT_W-1:0]  match_number;
    logic              last_hit;
  } hit_word_t;

  // Tracks the scanner's window, fill level and hit count as the words are
  // accepted, and keeps the match reports that must come out, oldest first.
  class scan_scoreboard;
    bit [63:0] pat_word [4];
    bit [31:0] care;
    bit [5:0]  plen = 6'd1;
    bit [15:0] max_hits = 16'd1;
    bit [7:0]  window [SCAN_DEPTH];
    int        fill;
    int        hit_count;
    hit_word_t pending_hits [$];
    int        errors;
    int        checked;

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] d);
      case (idx)
        REG_PATTERN_A: pat_word[0] = d;
        REG_PATTERN_B: pat_word[1] = d;
        REG_PATTERN_C: pat_word[2] = d;
        REG_PATTERN_D: pat_word[3] = d;
        REG_CARE_MASK: care = d[31:0];
        REG_PAT_LEN:   plen = d[5:0];
        REG_MAX_HITS:  max_hits = d[15:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      if (plen == 6'd0) return 1;
      if (int'(plen) > SCAN_DEPTH) return SCAN_DEPTH;
      return int'(plen);
    endfunction

    function bit [7:0] pattern_byte(int pos);
      return pat_word[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    function bit pattern_care(int pos);
      return (pos < 32) && care[pos];
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    // Shift the byte in and work out whether it completes a reportable match.
    function void note_byte(scan_word_t w);
      int        len;
      bit        hit;
      hit_word_t h;
      len = eff_len();
      if (w.search) begin
        hit_count = 0;
        fill = 0;
      end
      if (w.region) fill = 0;
      for (int i = SCAN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = w.data;
      if (fill < SCAN_DEPTH) fill++;
      if (fill < len || hit_count >= int'(max_hits)) return;
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (pattern_care(i) && window[len - 1 - i] != pattern_byte(i)) hit = 1'b0;
      end
      if (!hit) return;
      hit_count++;
      h.match_address = w.addr - 64'(len - 1);
      h.match_number  = 16'(hit_count);
      h.last_hit      = (hit_count >= int'(max_hits));
      pending_hits = {pending_hits, h};
    endfunction

    function void check_hit(hit_word_t got);
      hit_word_t want;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected match report, address %h number %0d last %0b",
                 $time, got.match_address, got.match_number, got.last_hit);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      checked++;
      if (got.match_address !== want.match_address) begin
        $display("%0t: match_address expected %h actual %h",
                 $time, want.match_address, got.match_address);
        errors++;
      end
      if (got.match_number !== want.match_number) begin
        $display("%0t: match_number expected %0d actual %0d",
                 $time, want.match_number, got.match_number);
        errors++;
      end
      if (got.last_hit !== want.last_hit) begin
        $display("%0t: last_hit expected %0b actual %0b", $time, want.last_hit, got.last_hit);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mbss_in_if  scan_in ();
  mbss_out_if hit_out ();
  mbss_cfg_if cfg ();

  masked_byte_signature_scan DUT (
    .clk     (clk),
    .rst     (rst),
    .scan_in (scan_in),
    .hit_out (hit_out),
    .cfg     (cfg)
  );

  scan_scoreboard sb = new;

  // Knobs shared by the byte driver and the result sink. The calm flag turns
  // off all random idling for the last stretch of the run.
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  bit calm;
  bit hold_request;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one byte word and hold it until the scanner takes it. A random idle
  // burst may come first, so gaps land on every stage of the pipeline.
  task automatic put_byte(input logic [7:0] b, input logic [63:0] a,
                          input logic rs, input logic ss);
    scan_word_t w;
    w.data   = b;
    w.addr   = a;
    w.region = rs;
    w.search = ss;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      scan_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    scan_in.valid        <= 1'b1;
    scan_in.data_byte    <= b;
    scan_in.byte_address <= a;
    scan_in.region_start <= rs;
    scan_in.search_start <= ss;
    do @(posedge clk); while (!scan_in.ready);
    sb.note_byte(w);
    items_sent++;
  endtask

  // Stop offering bytes and wait until every predicted report has arrived.
  task automatic pause_for_results();
    scan_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A byte that gives no report may still sit in the compare stage when the
  // last report arrives, so let the pipeline run dry before touching registers.
  task automatic settle_for_config();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the valid stays up so that back-to-back writes are legal.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
  endtask

  // Load a full search setup. With junk set, the unused upper bits of the
  // narrow registers carry random values that the scanner has to drop.
  task automatic load_search_config(input logic [3:0][63:0] pat, input logic [31:0] mask,
                                    input logic [5:0] plen, input logic [15:0] maxh,
                                    input bit junk);
    logic [63:0] hi;
    hi = junk ? rand64() : 64'd0;
    write_reg(REG_PATTERN_A, pat[0]);
    write_reg(REG_PATTERN_B, pat[1]);
    write_reg(REG_PATTERN_C, pat[2]);
    write_reg(REG_PATTERN_D, pat[3]);
    write_reg(REG_CARE_MASK, {hi[63:32], mask});
    write_reg(REG_PAT_LEN, {hi[63:6], plen});
    write_reg(REG_SPARE, rand64());
    write_reg(REG_MAX_HITS, {hi[63:16], maxh});
    cfg.valid <= 1'b0;
  endtask

  // One region of consecutive addresses. Stretches of it are the pattern
  // itself, with random bytes in wildcard positions; the rest is noise drawn
  // half from the pattern's own bytes so that near misses are common. Now and
  // then a stray region or search start breaks a sequence in the middle.
  task automatic send_region(input int n, input bit new_search, input int plant_pct);
    logic [63:0] base;
    logic [7:0]  b;
    int          len;
    int          k;
    case ($urandom_range(0, 3))
      0:       base = 64'd0;
      1:       base = '1 - 64'($urandom_range(0, 40));
      default: base = rand64();
    endcase
    len = sb.eff_len();
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < plant_pct && k + len <= n) begin
        for (int i = 0; i < len; i++) begin
          b = sb.pattern_care(i) ? sb.pattern_byte(i) : 8'($urandom_range(0, 255));
          put_byte(b, base + 64'(k), k == 0, new_search && k == 0);
          k++;
        end
      end else begin
        b = $urandom_range(0, 1) ? sb.pattern_byte($urandom_range(0, len - 1))
                                 : 8'($urandom_range(0, 255));
        put_byte(b, base + 64'(k), k == 0 || $urandom_range(0, 99) == 0,
                 (new_search && k == 0) || $urandom_range(0, 199) == 0);
        k++;
      end
    end
  endtask

  // Result sink: random short stalls, or one long hold-off on request while
  // the driver keeps offering bytes, so the scanner fills up and stalls.
  initial begin : result_sink
    hit_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hit_out.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hit_out.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        hit_out.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        hit_out.ready <= 1'b1;
      end else begin
        hit_out.ready <= 1'b1;
      end
    end
  end

  // Every report taken at a clock edge goes straight to the scoreboard.
  always @(posedge clk) begin : report_monitor
    hit_word_t got;
    if (!rst && hit_out.valid && hit_out.ready) begin
      got.match_address = hit_out.match_address;
      got.match_number  = hit_out.match_number;
      got.last_hit      = hit_out.last_hit;
      sb.check_hit(got);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((scan_in.valid && scan_in.ready) || (hit_out.valid && hit_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d reports still expected",
                 $time, quiet_cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [3:0][63:0] pat;
    logic [31:0]      mask;
    logic [5:0]       plen;
    logic [15:0]      maxh;
    logic [63:0]      base;
    logic [7:0]       sig [4];
    int               phase;
    int               plant_pct;
    int               phase_end;
    int               n;

    rst                  <= 1'b1;
    scan_in.valid        <= 1'b0;
    scan_in.data_byte    <= 8'd0;
    scan_in.byte_address <= 64'd0;
    scan_in.region_start <= 1'b0;
    scan_in.search_start <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.index            <= REG_PATTERN_A;
    cfg.data             <= 64'd0;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset setup: one wildcard position and a limit of one, so the first byte
    // of each search is a hit and everything after it is over the limit.
    put_byte(8'h00, 64'd0, 1'b1, 1'b1);
    put_byte(8'hFF, 64'd1, 1'b0, 1'b0);
    put_byte(8'hFF, '1, 1'b1, 1'b1);
    put_byte(8'h5A, 64'd0, 1'b0, 1'b0);

    // Four-byte signature with the third position as a wildcard, two hits per
    // search. The first match starts two bytes below the top of the address
    // space, so its start address is the wrapped one.
    settle_for_config();
    load_search_config({64'd0, 64'd0, 64'd0, 64'h0000_0000_4433_2211},
                       32'h0000_000B, 6'd4, 16'd2, 1'b0);
    sig[0] = 8'h11;
    sig[1] = 8'h22;
    sig[2] = 8'h33;
    sig[3] = 8'h44;
    base = 64'hFFFF_FFFF_FFFF_FFFE;
    put_byte(8'h11, base, 1'b1, 1'b1);
    put_byte(8'h22, base + 64'd1, 1'b0, 1'b0);
    put_byte(8'h99, base + 64'd2, 1'b0, 1'b0);
    put_byte(8'h44, base + 64'd3, 1'b0, 1'b0);
    // A region break in the middle of the signature must not give a match.
    put_byte(8'h11, base + 64'd4, 1'b0, 1'b0);
    put_byte(8'h22, base + 64'd5, 1'b0, 1'b0);
    put_byte(8'h33, 64'h1000, 1'b1, 1'b0);
    put_byte(8'h44, 64'h1001, 1'b0, 1'b0);
    // Second hit reaches the limit; the third signature is then ignored, and a
    // new search counts from one again.
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 4; i++) begin
        put_byte(sig[i], 64'h1002 + 64'(4 * r + i), 1'b0, r == 2 && i == 0);
      end
    end

    // A limit of zero means nothing is ever reported.
    settle_for_config();
    load_search_config('0, 32'd0, 6'd1, 16'd0, 1'b1);
    put_byte(8'h00, 64'h20, 1'b1, 1'b1);
    put_byte(8'hFF, 64'h21, 1'b0, 1'b0);

    // Random phases, each under a fresh setup. The setups rotate through full
    // length with every position cared for, a length of zero, all wildcards,
    // short signatures, random lengths with low limits, and lengths at and
    // past the window depth with uniform pattern bytes.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_for_config();
      calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
      for (int i = 0; i < 4; i++) pat[i] = rand64();
      mask = $urandom;
      case (phase % 6)
        0: begin
          mask = '1;
          plen = 6'd63;
          maxh = 16'hFFFF;
          plant_pct = 35;
        end
        1: begin
          plen = 6'd0;
          maxh = 16'($urandom_range(1, 4));
          plant_pct = 10;
        end
        2: begin
          mask = '0;
          plen = 6'($urandom_range(1, 40));
          maxh = 16'hFFFF;
          plant_pct = 0;
        end
        3: begin
          plen = 6'($urandom_range(1, 8));
          maxh = 16'($urandom_range(1, 6));
          plant_pct = 15;
        end
        4: begin
          mask = $urandom | $urandom;
          plen = 6'($urandom_range(0, 63));
          maxh = 16'($urandom_range(0, 3));
          plant_pct = 25;
        end
        default: begin
          pat = $urandom_range(0, 1) ? '1 : '0;
          plen = $urandom_range(0, 1) ? 6'd33 : 6'd32;
          maxh = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
          plant_pct = 30;
        end
      endcase
      load_search_config(pat, mask, plen, maxh, $urandom_range(0, 2) == 0);

      case ($urandom_range(0, 2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 4;
        default: send_idle_pct = 15;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_idle_pct = 0;
        1:       recv_idle_pct = 4;
        default: recv_idle_pct = 15;
      endcase

      // With all positions wildcards every byte is a hit once the window is filled
      // to the length, so this is the phase for the long result hold-off: the driver
      // keeps offering bytes without gaps until the scanner backs up to its input.
      if (phase == 2) begin
        send_idle_pct = 0;
        hold_request = 1'b1;
      end

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
        send_region(n, items_sent + n >= phase_end - PHASE_ITEMS / 2 && phase == 3
                       || $urandom_range(0, 2) == 0, plant_pct);
        // In the second half of one phase, the driver stops between regions
        // until it has seen every report it is owed.
        if (phase == 3 && items_sent >= phase_end - PHASE_ITEMS / 2 && sb.pending() != 0)
          pause_for_results();
      end
      phase++;
    end

    pause_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Scanned %0d bytes under %0d random setups after the directed cases;",
             items_sent, phase);
    $display("%0d match reports checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
